FILE: rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the project.
// No dependencies; the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define BPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bpa assertion failed");

// Check a property at every clock edge, reset included.
`define BPA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bpa assertion failed");

`endif

FILE: rtl/core/bpa_pkg.sv
// Types, constants and codes of the buddy page allocator.
// No dependencies; used by every RTL module of the block.
package bpa_pkg;

  localparam int NUM_PAGES  = 4096;
  localparam int NUM_ORDERS = 11;
  localparam int PAGE_W     = $clog2(NUM_PAGES);
  localparam int LINK_W     = PAGE_W + 1;
  localparam int ORD_W      = 4;
  localparam int OIDX_W     = $clog2(NUM_ORDERS);
  localparam int CNT_W      = 13;
  localparam int IDX_W      = NUM_ORDERS;
  localparam int MARK_W     = 4;
  localparam int CFG_W      = 32;
  localparam int CFG_AW     = 3;

  localparam logic [LINK_W-1:0] NIL       = LINK_W'(NUM_PAGES);
  localparam logic [PAGE_W-1:0] HIGH_RST  = PAGE_W'(4095);

  typedef logic [MARK_W-1:0] mark_t;
  localparam mark_t MK_NONE = 4'd0;
  localparam mark_t MK_FREE = 4'd1;
  localparam mark_t MK_USED = 4'd2;
  localparam mark_t MK_HEAD = 4'd4;
  localparam mark_t MK_BODY = 4'd8;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFREE = 2'd1,
    ST_ORDER  = 2'd2,
    ST_BAD    = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_ADD_RD,
    S_ADD_EV,
    S_F_RD,
    S_F_EV,
    S_F_BODY,
    S_M_RD,
    S_M_EV,
    S_M_END,
    S_PUSH2,
    S_A_SRCH,
    S_A_RD,
    S_A_REM,
    S_A_SPL,
    S_A_HEAD,
    S_A_BODY,
    S_DONE
  } state_t;

endpackage

FILE: rtl/core/bpa_ram.sv
// Single-write, single-read page state memory with registered read data.
// Depends on bpa_pkg for the page count.
module bpa_ram #(
  parameter int W = 4
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [bpa_pkg::PAGE_W-1:0] waddr,
  input  logic [W-1:0]               wdata,
  input  logic [bpa_pkg::PAGE_W-1:0] raddr,
  output logic [W-1:0]               rdata
);

  logic [W-1:0] mem_r [bpa_pkg::NUM_PAGES];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/buddy_page_allocator.sv
// Binary buddy allocator over 4096 page frames with 11 doubly linked LIFO free
// lists. After reset the block sweeps its page state memories, one page a
// cycle, before it takes the first item (configuration writes are taken at
// once). One item is worked at a time under a small sequencer; every step
// makes at most one write to each page state memory, and read data is
// registered, so it comes back in the cycle after its address. An add probes
// the containing block at each order, then merges with free buddies; a free
// clears the body pages, then merges; an allocate searches the lists upward
// from the requested order, splits the block down to that order and marks
// its body pages. Depends on bpa_pkg, bpa_ram.
module buddy_page_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_op,
  input  logic [bpa_pkg::ORD_W-1:0]        in_order,
  input  logic [bpa_pkg::PAGE_W-1:0]       in_page_number,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bpa_pkg::PAGE_W-1:0]       out_block_page,
  output logic [1:0]                       out_status,
  output logic [bpa_pkg::CNT_W-1:0]        out_free_pages,
  output logic [bpa_pkg::CNT_W-1:0]        out_total_pages,
  // configuration port
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [bpa_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [bpa_pkg::CFG_W-1:0]        cfg_pwdata,
  output logic [bpa_pkg::CFG_W-1:0]        cfg_prdata,
  output logic                             cfg_pready
);

  localparam int PW = bpa_pkg::PAGE_W;
  localparam int LW = bpa_pkg::LINK_W;
  localparam int OW = bpa_pkg::ORD_W;
  localparam int XW = bpa_pkg::OIDX_W;
  localparam int CW = bpa_pkg::CNT_W;
  localparam int IW = bpa_pkg::IDX_W;
  localparam int MW = bpa_pkg::MARK_W;

  // sequencer and item registers
  bpa_pkg::state_t  state_r, state_nxt;
  bpa_pkg::op_t     op_r, op_nxt;
  logic [OW-1:0]    ord_r, ord_nxt;      // requested order
  logic [PW-1:0]    pg_r, pg_nxt;        // page of add or free
  logic [PW-1:0]    p_r, p_nxt;          // current block page
  logic [OW-1:0]    o_r, o_nxt;          // current order
  logic [PW-1:0]    h_r, h_nxt;          // allocated head
  logic [IW-1:0]    idx_r, idx_nxt;      // body page offset
  logic [OW-1:0]    kk_r, kk_nxt;        // containing-block probe order
  logic [PW-1:0]    clr_r, clr_nxt;      // clearing sweep address
  logic [PW-1:0]    blk_r, blk_nxt;
  bpa_pkg::status_t st_r, st_nxt;

  // allocator state
  logic [LW-1:0]    heads_r [bpa_pkg::NUM_ORDERS];
  logic [LW-1:0]    heads_nxt [bpa_pkg::NUM_ORDERS];
  logic [CW-1:0]    free_r, free_nxt;
  logic [CW-1:0]    total_r, total_nxt;
  logic [PW-1:0]    highest_r, highest_nxt;

  // result register
  logic             out_valid_r, out_valid_nxt;
  logic [PW-1:0]    out_blk_r, out_blk_nxt;
  logic [1:0]       out_st_r, out_st_nxt;
  logic [CW-1:0]    out_free_r, out_free_nxt;
  logic [CW-1:0]    out_total_r, out_total_nxt;

  // page state memory ports
  logic             ord_we, mark_we, prv_we, nxt_we;
  logic [PW-1:0]    ord_wa, mark_wa, prv_wa, nxt_wa;
  logic [OW-1:0]    ord_wd;
  bpa_pkg::mark_t   mark_wd;
  logic [LW-1:0]    prv_wd, nxt_wd;
  logic [PW-1:0]    rd_addr;
  logic [OW-1:0]    ord_rd;
  bpa_pkg::mark_t   mark_rd;
  logic [LW-1:0]    prv_rd, nxt_rd;

  bpa_ram #(.W(OW)) u_ord (
    .clk(clk), .we(ord_we), .waddr(ord_wa), .wdata(ord_wd),
    .raddr(rd_addr), .rdata(ord_rd)
  );
  bpa_ram #(.W(MW)) u_mark (
    .clk(clk), .we(mark_we), .waddr(mark_wa), .wdata(mark_wd),
    .raddr(rd_addr), .rdata(mark_rd)
  );
  bpa_ram #(.W(LW)) u_prv (
    .clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
    .raddr(rd_addr), .rdata(prv_rd)
  );
  bpa_ram #(.W(LW)) u_nxt (
    .clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
    .raddr(rd_addr), .rdata(nxt_rd)
  );

  // Shared page adder: body page addresses and split buddies.
  logic [LW-1:0]    add_a, add_b, add_sum;
  logic             q_valid;
  logic [OW-1:0]    o_dn;
  logic [PW-1:0]    h_add, add_diff, b_merge;
  logic [IW-1:0]    cnt_o;
  logic             add_bad, free_bad, merge_stop, merge_ok;
  logic             hd_valid, out_free, cfg_wr;
  logic [OW-1:0]    push_o;
  logic [PW-1:0]    push_p;
  logic [LW-1:0]    hd_cur, hd_push;
  logic [PW-1:0]    mrg_lo, mrg_hi;

  assign o_dn = o_r - OW'(1);

  always_comb begin
    add_a = {1'b0, h_r};
    add_b = LW'(idx_r);
    unique case (state_r)
      bpa_pkg::S_F_BODY: add_a = {1'b0, pg_r};
      bpa_pkg::S_A_SPL:  add_b = LW'(1) << o_dn;
      default: ;
    endcase
  end

  assign add_sum = add_a + add_b;
  assign q_valid = !add_sum[PW];

  // probe the block of order kk that would contain the added page
  assign h_add    = pg_r & ~((PW'(1) << kk_r) - PW'(1));
  assign add_diff = pg_r - h_add;
  assign add_bad  = ((kk_r == '0) && (mark_rd != bpa_pkg::MK_NONE)) ||
                    (((mark_rd & bpa_pkg::MK_FREE) != bpa_pkg::MK_NONE) &&
                     ((add_diff >> ord_rd) == '0));
  assign free_bad = ((mark_rd & bpa_pkg::MK_FREE) != bpa_pkg::MK_NONE) ||
                    ((mark_rd & bpa_pkg::MK_USED) == bpa_pkg::MK_NONE) ||
                    ((mark_rd & bpa_pkg::MK_BODY) != bpa_pkg::MK_NONE);

  // merge: buddy of the current block, stop at the top order or above the limit
  assign b_merge    = p_r ^ (PW'(1) << o_r);
  assign merge_stop = ((5'(o_r) + 5'd1) >= 5'(bpa_pkg::NUM_ORDERS)) ||
                      (b_merge > highest_r);
  assign merge_ok   = ((mark_rd & bpa_pkg::MK_FREE) != bpa_pkg::MK_NONE) &&
                      (ord_rd == o_r);
  assign mrg_lo     = (b_merge < p_r) ? b_merge : p_r;
  assign mrg_hi     = (b_merge < p_r) ? p_r : b_merge;

  assign cnt_o    = IW'(1) << o_r;
  assign hd_cur   = heads_r[o_r[XW-1:0]];
  assign hd_valid = !hd_cur[PW];
  assign push_o   = (state_r == bpa_pkg::S_A_SPL) ? o_dn : o_r;
  assign push_p   = (state_r == bpa_pkg::S_A_SPL) ? add_sum[PW-1:0] : p_r;
  assign hd_push  = heads_r[push_o[XW-1:0]];

  assign out_free = !out_valid_r || !out_stall;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bpa_pkg::S_CLEAR:  if (clr_r == '1) state_nxt = bpa_pkg::S_IDLE;
      bpa_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (bpa_pkg::op_t'(in_op))
            bpa_pkg::OP_ADD:   state_nxt = bpa_pkg::S_ADD_RD;
            bpa_pkg::OP_ALLOC: state_nxt = (5'(in_order) >= 5'(bpa_pkg::NUM_ORDERS)) ?
                                           bpa_pkg::S_DONE : bpa_pkg::S_A_SRCH;
            bpa_pkg::OP_FREE:  state_nxt = bpa_pkg::S_F_RD;
            bpa_pkg::OP_NONE:  state_nxt = bpa_pkg::S_DONE;
          endcase
        end
      end
      bpa_pkg::S_ADD_RD: state_nxt = bpa_pkg::S_ADD_EV;
      bpa_pkg::S_ADD_EV: begin
        priority if (add_bad) state_nxt = bpa_pkg::S_DONE;
        else if (32'(kk_r) == bpa_pkg::NUM_ORDERS - 1) state_nxt = bpa_pkg::S_M_RD;
        else state_nxt = bpa_pkg::S_ADD_RD;
      end
      bpa_pkg::S_F_RD:   state_nxt = bpa_pkg::S_F_EV;
      bpa_pkg::S_F_EV:   state_nxt = free_bad ? bpa_pkg::S_DONE : bpa_pkg::S_F_BODY;
      bpa_pkg::S_F_BODY: if (idx_r == cnt_o) state_nxt = bpa_pkg::S_M_RD;
      bpa_pkg::S_M_RD:   state_nxt = merge_stop ? bpa_pkg::S_M_END : bpa_pkg::S_M_EV;
      bpa_pkg::S_M_EV:   state_nxt = merge_ok ? bpa_pkg::S_M_RD : bpa_pkg::S_M_END;
      bpa_pkg::S_M_END:  state_nxt = bpa_pkg::S_PUSH2;
      bpa_pkg::S_PUSH2:  state_nxt = (op_r == bpa_pkg::OP_ALLOC) ?
                                     bpa_pkg::S_A_SPL : bpa_pkg::S_DONE;
      bpa_pkg::S_A_SRCH: begin
        priority if (hd_valid) state_nxt = bpa_pkg::S_A_RD;
        else if (32'(o_r) == bpa_pkg::NUM_ORDERS - 1) state_nxt = bpa_pkg::S_DONE;
        else state_nxt = bpa_pkg::S_A_SRCH;
      end
      bpa_pkg::S_A_RD:   state_nxt = bpa_pkg::S_A_REM;
      bpa_pkg::S_A_REM:  state_nxt = bpa_pkg::S_A_SPL;
      bpa_pkg::S_A_SPL: begin
        priority if (o_r == ord_r) state_nxt = bpa_pkg::S_A_HEAD;
        else if (q_valid) state_nxt = bpa_pkg::S_PUSH2;
        else state_nxt = bpa_pkg::S_A_SPL;
      end
      bpa_pkg::S_A_HEAD: state_nxt = bpa_pkg::S_A_BODY;
      bpa_pkg::S_A_BODY: if (idx_r == cnt_o) state_nxt = bpa_pkg::S_DONE;
      bpa_pkg::S_DONE:   if (out_free) state_nxt = bpa_pkg::S_IDLE;
    endcase
  end

  // datapath and memory ports
  always_comb begin
    op_nxt      = op_r;
    ord_nxt     = ord_r;
    pg_nxt      = pg_r;
    p_nxt       = p_r;
    o_nxt       = o_r;
    h_nxt       = h_r;
    idx_nxt     = idx_r;
    kk_nxt      = kk_r;
    clr_nxt     = clr_r;
    blk_nxt     = blk_r;
    st_nxt      = st_r;
    heads_nxt   = heads_r;
    free_nxt    = free_r;
    total_nxt   = total_r;
    highest_nxt = cfg_wr ? cfg_pwdata[PW-1:0] : highest_r;
    ord_we  = 1'b0;  ord_wa  = '0;  ord_wd  = '0;
    mark_we = 1'b0;  mark_wa = '0;  mark_wd = bpa_pkg::MK_NONE;
    prv_we  = 1'b0;  prv_wa  = '0;  prv_wd  = '0;
    nxt_we  = 1'b0;  nxt_wa  = '0;  nxt_wd  = '0;
    rd_addr = p_r;
    out_blk_nxt   = out_blk_r;
    out_st_nxt    = out_st_r;
    out_free_nxt  = out_free_r;
    out_total_nxt = out_total_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      bpa_pkg::S_CLEAR: begin
        ord_we = 1'b1;  ord_wa = clr_r;
        mark_we = 1'b1; mark_wa = clr_r;
        prv_we = 1'b1;  prv_wa = clr_r;  prv_wd = bpa_pkg::NIL;
        nxt_we = 1'b1;  nxt_wa = clr_r;  nxt_wd = bpa_pkg::NIL;
        clr_nxt = clr_r + PW'(1);
      end
      bpa_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = bpa_pkg::op_t'(in_op);
          ord_nxt = in_order;
          pg_nxt  = in_page_number;
          o_nxt   = in_order;
          kk_nxt  = '0;
          blk_nxt = '0;
          st_nxt  = ((bpa_pkg::op_t'(in_op) == bpa_pkg::OP_ALLOC) &&
                     (5'(in_order) >= 5'(bpa_pkg::NUM_ORDERS))) ?
                    bpa_pkg::ST_ORDER : bpa_pkg::ST_OK;
        end
      end
      bpa_pkg::S_ADD_RD: rd_addr = h_add;
      bpa_pkg::S_ADD_EV: begin
        priority if (add_bad) begin
          st_nxt = bpa_pkg::ST_BAD;
        end else if (32'(kk_r) == bpa_pkg::NUM_ORDERS - 1) begin
          p_nxt     = pg_r;
          o_nxt     = '0;
          free_nxt  = free_r + CW'(1);
          total_nxt = total_r + CW'(1);
        end else begin
          kk_nxt = kk_r + OW'(1);
        end
      end
      bpa_pkg::S_F_RD: rd_addr = pg_r;
      bpa_pkg::S_F_EV: begin
        if (free_bad) begin
          st_nxt = bpa_pkg::ST_BAD;
        end else begin
          o_nxt    = ord_rd;
          p_nxt    = pg_r;
          idx_nxt  = IW'(1);
          free_nxt = free_r + (CW'(1) << ord_rd);
        end
      end
      bpa_pkg::S_F_BODY, bpa_pkg::S_A_BODY: begin
        // one body page a cycle: clear on free, mark on allocate
        if (idx_r != cnt_o) begin
          if (q_valid) begin
            ord_we  = 1'b1;
            ord_wa  = add_sum[PW-1:0];
            mark_we = 1'b1;
            mark_wa = add_sum[PW-1:0];
            if (state_r == bpa_pkg::S_A_BODY) begin
              ord_wd  = ord_r;
              mark_wd = bpa_pkg::MK_USED | bpa_pkg::MK_BODY;
            end
          end
          idx_nxt = idx_r + IW'(1);
        end
      end
      bpa_pkg::S_M_RD: rd_addr = b_merge;
      bpa_pkg::S_M_EV, bpa_pkg::S_A_REM: begin
        // unlink the page just read from list o_r
        if ((state_r == bpa_pkg::S_A_REM) || merge_ok) begin
          if (!prv_rd[PW]) begin
            nxt_we = 1'b1;
            nxt_wa = prv_rd[PW-1:0];
            nxt_wd = nxt_rd;
          end else begin
            heads_nxt[o_r[XW-1:0]] = nxt_rd;
          end
          if (!nxt_rd[PW]) begin
            prv_we = 1'b1;
            prv_wa = nxt_rd[PW-1:0];
            prv_wd = prv_rd;
          end
        end
        if ((state_r == bpa_pkg::S_M_EV) && merge_ok) begin
          // the upper buddy disappears inside the merged block
          ord_we  = 1'b1;
          ord_wa  = mrg_hi;
          mark_we = 1'b1;
          mark_wa = mrg_hi;
          p_nxt   = mrg_lo;
          o_nxt   = o_r + OW'(1);
        end
      end
      bpa_pkg::S_M_END, bpa_pkg::S_A_SPL: begin
        if ((state_r == bpa_pkg::S_M_END) || ((o_r != ord_r) && q_valid)) begin
          // push the block at the head of its list
          ord_we  = 1'b1;
          ord_wa  = push_p;
          ord_wd  = push_o;
          mark_we = 1'b1;
          mark_wa = push_p;
          mark_wd = bpa_pkg::MK_FREE |
                    ((push_o != '0) ? bpa_pkg::MK_HEAD : bpa_pkg::MK_NONE);
          nxt_we  = 1'b1;
          nxt_wa  = push_p;
          nxt_wd  = hd_push;
          if (!hd_push[PW]) begin
            prv_we = 1'b1;
            prv_wa = hd_push[PW-1:0];
            prv_wd = {1'b0, push_p};
          end
          heads_nxt[push_o[XW-1:0]] = {1'b0, push_p};
          p_nxt = push_p;
        end
        if ((state_r == bpa_pkg::S_A_SPL) && (o_r != ord_r)) begin
          o_nxt = o_dn;
        end
      end
      bpa_pkg::S_PUSH2: begin
        prv_we = 1'b1;
        prv_wa = p_r;
        prv_wd = bpa_pkg::NIL;
      end
      bpa_pkg::S_A_SRCH: begin
        priority if (hd_valid) begin
          h_nxt = hd_cur[PW-1:0];
        end else if (32'(o_r) == bpa_pkg::NUM_ORDERS - 1) begin
          st_nxt = bpa_pkg::ST_NOFREE;
        end else begin
          o_nxt = o_r + OW'(1);
        end
      end
      bpa_pkg::S_A_RD: rd_addr = h_r;
      bpa_pkg::S_A_HEAD: begin
        ord_we   = 1'b1;
        ord_wa   = h_r;
        ord_wd   = ord_r;
        mark_we  = 1'b1;
        mark_wa  = h_r;
        mark_wd  = bpa_pkg::MK_USED |
                   ((ord_r != '0) ? bpa_pkg::MK_HEAD : bpa_pkg::MK_NONE);
        idx_nxt  = IW'(1);
        free_nxt = free_r - (CW'(1) << ord_r);
        blk_nxt  = h_r;
        st_nxt   = bpa_pkg::ST_OK;
      end
      bpa_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = blk_r;
          out_st_nxt    = st_r;
          out_free_nxt  = free_r;
          out_total_nxt = total_r;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpa_pkg::S_CLEAR;
      clr_r       <= '0;
      free_r      <= '0;
      total_r     <= '0;
      highest_r   <= bpa_pkg::HIGH_RST;
      out_valid_r <= 1'b0;
      for (int i = 0; i < bpa_pkg::NUM_ORDERS; i++) begin
        heads_r[i] <= bpa_pkg::NIL;
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      free_r      <= free_nxt;
      total_r     <= total_nxt;
      highest_r   <= highest_nxt;
      out_valid_r <= out_valid_nxt;
      heads_r     <= heads_nxt;
    end
  end

  // item and result payload: no reset needed
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ord_r       <= ord_nxt;
    pg_r        <= pg_nxt;
    p_r         <= p_nxt;
    o_r         <= o_nxt;
    h_r         <= h_nxt;
    idx_r       <= idx_nxt;
    kk_r        <= kk_nxt;
    blk_r       <= blk_nxt;
    st_r        <= st_nxt;
    out_blk_r   <= out_blk_nxt;
    out_st_r    <= out_st_nxt;
    out_free_r  <= out_free_nxt;
    out_total_r <= out_total_nxt;
  end

  // hold off new beats while an item is in work or the sweep runs
  assign in_stall        = (state_r != bpa_pkg::S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_block_page  = out_blk_r;
  assign out_status      = out_st_r;
  assign out_free_pages  = out_free_r;
  assign out_total_pages = out_total_r;
  assign cfg_pready      = 1'b1;
  assign cfg_prdata      = cfg_paddr[2] ? '0 : bpa_pkg::CFG_W'(highest_r);

endmodule

FILE: rtl/core/bpa_checker.sv
// Port-level checks of the buddy page allocator, bound to its top level.
// Depends on bpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bpa_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [bpa_pkg::PAGE_W-1:0] out_block_page,
  input logic [1:0]                 out_status,
  input logic [bpa_pkg::CNT_W-1:0]  out_free_pages,
  input logic [bpa_pkg::CNT_W-1:0]  out_total_pages
);

  `BPA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid)
  `BPA_ASSERT(a_busy_after_beat, in_valid && !in_stall |=> in_stall)
  `BPA_ASSERT(a_fail_no_page, out_valid && (out_status != bpa_pkg::ST_OK) |-> out_block_page == '0)
  `BPA_ASSERT(a_free_le_total, out_valid |-> out_free_pages <= out_total_pages)
  `BPA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid)

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
